FILE: sv/sctok_pkg.sv
package sctok_pkg;

  localparam int MAX_TOKEN_LEN_DEF = 128;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_NL    = 8'h0a;
  localparam logic [7:0] CHAR_SLASH = 8'h2f;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] SPACE_MAX  = 8'd32;

  localparam int RES_DEPTH = 3;

  typedef enum logic [2:0] {
    MODE_SKIP    = 3'd0,
    MODE_SLASH   = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_WORD    = 3'd3,
    MODE_QUOTED  = 3'd4
  } mode_t;

  typedef struct packed {
    logic [7:0] token_byte;
    logic       is_token_end;
    logic [7:0] token_length;
    logic       discarded;
    logic       was_quoted;
    logic       end_of_text;
  } res_t;

endpackage

FILE: sv/script_tokenizer_core.sv
// latency: the first result of a request is offered the cycle after it is accepted
// throughput: one request per cycle while out_ready is high and each request
// gives at most one result; one giving two or three holds in_ready low while
// the three-entry result queue drains, one result per cycle while out_ready is set
// reset: synchronous active-low rst_n returns scanning to whitespace skipping,
// clears the kept count, empties the result queue and sets high_space_r
module script_tokenizer_core #(
  parameter int MAX_TOKEN_LEN = sctok_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_token_byte,
  output logic       out_is_token_end,
  output logic [7:0] out_token_length,
  output logic       out_discarded,
  output logic       out_was_quoted,
  output logic       out_end_of_text
);
  import sctok_pkg::*;

  localparam logic [7:0] MAX_LEN = 8'(MAX_TOKEN_LEN);

  logic       high_space_r;
  mode_t      mode_r, mode_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [1:0] q_cnt_r, q_cnt_nxt;
  res_t       res_r   [RES_DEPTH];
  res_t       res_nxt [RES_DEPTH];
  res_t       new_res [RES_DEPTH];
  logic [1:0] new_n;
  logic       is_space;
  logic       accept;
  logic       pop;
  logic       disc;
  logic [7:0] b;

  assign b         = in_text_byte;
  assign out_valid = (q_cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign in_ready  = (q_cnt_r == 2'd0) || ((q_cnt_r == 2'd1) && out_ready);
  assign accept    = in_valid && in_ready;

  assign out_token_byte   = res_r[0].token_byte;
  assign out_is_token_end = res_r[0].is_token_end;
  assign out_token_length = res_r[0].token_length;
  assign out_discarded    = res_r[0].discarded;
  assign out_was_quoted   = res_r[0].was_quoted;
  assign out_end_of_text  = res_r[0].end_of_text;

  assign is_space = ((b != CHAR_NUL) && (b <= SPACE_MAX)) || (b[7] && high_space_r);
  assign disc     = (cnt_r >= MAX_LEN);

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    new_n    = 2'd0;
    for (int i = 0; i < RES_DEPTH; i++) begin
      new_res[i] = '0;
    end
    case (mode_r)
      MODE_SLASH: begin
        if (b == CHAR_SLASH) begin
          mode_nxt = MODE_COMMENT;
          cnt_nxt  = 8'd0;
        end else begin
          new_res[0].token_byte = CHAR_SLASH;
          mode_nxt = MODE_WORD;
          new_n    = 2'd2;
          if ((b == CHAR_NUL) || is_space) begin
            new_res[1].is_token_end = 1'b1;
            new_res[1].token_length = 8'd1;
            if (b == CHAR_NUL) begin
              new_res[2].end_of_text = 1'b1;
              new_n = 2'd3;
            end
            mode_nxt = MODE_SKIP;
            cnt_nxt  = 8'd0;
          end else begin
            new_res[1].token_byte = b;
            cnt_nxt = 8'd2;
          end
        end
      end
      MODE_COMMENT: begin
        if (b == CHAR_NUL) begin
          new_res[0].end_of_text = 1'b1;
          new_n    = 2'd1;
          mode_nxt = MODE_SKIP;
          cnt_nxt  = 8'd0;
        end else if (b == CHAR_NL) begin
          mode_nxt = MODE_SKIP;
        end
      end
      MODE_WORD: begin
        if ((b == CHAR_NUL) || is_space) begin
          new_res[0].is_token_end = 1'b1;
          new_res[0].token_length = disc ? 8'd0 : cnt_r;
          new_res[0].discarded    = disc;
          new_n = 2'd1;
          if (b == CHAR_NUL) begin
            new_res[1].end_of_text = 1'b1;
            new_n = 2'd2;
          end
          mode_nxt = MODE_SKIP;
          cnt_nxt  = 8'd0;
        end else if (!disc) begin
          new_res[0].token_byte = b;
          new_n   = 2'd1;
          cnt_nxt = cnt_r + 8'd1;
        end
      end
      MODE_QUOTED: begin
        if ((b == CHAR_QUOTE) || (b == CHAR_NUL)) begin
          new_res[0].is_token_end = 1'b1;
          new_res[0].token_length = cnt_r;
          new_res[0].was_quoted   = 1'b1;
          new_n = 2'd1;
          if (b == CHAR_NUL) begin
            new_res[1].end_of_text = 1'b1;
            new_n = 2'd2;
          end
          mode_nxt = MODE_SKIP;
          cnt_nxt  = 8'd0;
        end else if (!disc) begin
          new_res[0].token_byte = b;
          new_n   = 2'd1;
          cnt_nxt = cnt_r + 8'd1;
        end
      end
      default: begin
        mode_nxt = MODE_SKIP;
        cnt_nxt  = 8'd0;
        if (b == CHAR_NUL) begin
          new_res[0].end_of_text = 1'b1;
          new_n = 2'd1;
        end else if (is_space) begin
          mode_nxt = MODE_SKIP;
        end else if (b == CHAR_SLASH) begin
          mode_nxt = MODE_SLASH;
        end else if (b == CHAR_QUOTE) begin
          mode_nxt = MODE_QUOTED;
        end else begin
          new_res[0].token_byte = b;
          new_n    = 2'd1;
          mode_nxt = MODE_WORD;
          cnt_nxt  = 8'd1;
        end
      end
    endcase
  end

  always_comb begin
    q_cnt_nxt = q_cnt_r;
    for (int i = 0; i < RES_DEPTH; i++) begin
      res_nxt[i] = res_r[i];
    end
    if (accept) begin
      q_cnt_nxt = new_n;
      for (int i = 0; i < RES_DEPTH; i++) begin
        res_nxt[i] = new_res[i];
      end
    end else if (pop) begin
      q_cnt_nxt = q_cnt_r - 2'd1;
      for (int i = 0; i < RES_DEPTH - 1; i++) begin
        res_nxt[i] = res_r[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_space_r <= 1'b1;
      mode_r       <= MODE_SKIP;
      cnt_r        <= 8'd0;
      q_cnt_r      <= 2'd0;
    end else begin
      if (cfg_we) begin
        high_space_r <= cfg_wdata;
      end
      if (accept) begin
        mode_r <= mode_nxt;
        cnt_r  <= cnt_nxt;
      end
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_DEPTH; i++) begin
      res_r[i] <= res_nxt[i];
    end
  end

  a_nul_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_text_byte == CHAR_NUL) |=> (mode_r == MODE_SKIP) && (cnt_r == 8'd0))
    else $error("nul did not return scanning to skip");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_LEN)
    else $error("kept count beyond max token length");

  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (q_cnt_r <= 2'd1))
    else $error("ready with results still queued");

  a_queue_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept && !pop |=> $stable(q_cnt_r))
    else $error("result queue changed without request or pop");

endmodule

FILE: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sctok_pkg::*;

  localparam int MAX_LEN     = MAX_TOKEN_LEN_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 6;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_text_byte;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_token_byte;
  logic       out_is_token_end;
  logic [7:0] out_token_length;
  logic       out_discarded;
  logic       out_was_quoted;
  logic       out_end_of_text;

  script_tokenizer_core #(.MAX_TOKEN_LEN(MAX_LEN)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_byte   (out_token_byte),
    .out_is_token_end (out_is_token_end),
    .out_token_length (out_token_length),
    .out_discarded    (out_discarded),
    .out_was_quoted   (out_was_quoted),
    .out_end_of_text  (out_end_of_text)
  );

  always #5 clk = ~clk;

  // tokenizer shadow state
  mode_t      scan_state;
  logic [7:0] kept_bytes;
  logic       high_space;
  res_t       pending_results [$];

  int   error_count;
  int   cycle_count;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_len;
  logic out_hold;
  event hold_go;
  res_t want;

  function automatic bit is_text_space(logic [7:0] b);
    return (b >= 8'd1 && b <= SPACE_MAX) || (b[7] && high_space);
  endfunction

  task automatic push_result(logic [7:0] tb, logic te, logic [7:0] len, logic disc,
                             logic quoted, logic eot);
    res_t r;
    r.token_byte   = tb;
    r.is_token_end = te;
    r.token_length = len;
    r.discarded    = disc;
    r.was_quoted   = quoted;
    r.end_of_text  = eot;
    pending_results.push_back(r);
  endtask

  task automatic keep_token_byte(logic [7:0] b);
    if (kept_bytes < MAX_LEN) begin
      kept_bytes = kept_bytes + 8'd1;
      push_result(b, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
    end
  endtask

  task automatic word_text_byte(logic [7:0] b);
    bit disc;
    if (b == CHAR_NUL || is_text_space(b)) begin
      disc = kept_bytes >= MAX_LEN;
      push_result(8'd0, 1'b1, disc ? 8'd0 : kept_bytes, disc, 1'b0, 1'b0);
      if (b == CHAR_NUL) push_result(8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1);
      scan_state = MODE_SKIP;
      kept_bytes = 8'd0;
    end else begin
      keep_token_byte(b);
    end
  endtask

  task automatic tokenize_byte(logic [7:0] b);
    case (scan_state)
      MODE_SLASH: begin
        kept_bytes = 8'd0;
        if (b == CHAR_SLASH) begin
          scan_state = MODE_COMMENT;
        end else begin
          scan_state = MODE_WORD;
          keep_token_byte(CHAR_SLASH);
          word_text_byte(b);
        end
      end
      MODE_COMMENT: begin
        if (b == CHAR_NUL) begin
          scan_state = MODE_SKIP;
          kept_bytes = 8'd0;
          push_result(8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1);
        end else if (b == CHAR_NL) begin
          scan_state = MODE_SKIP;
        end
      end
      MODE_WORD: word_text_byte(b);
      MODE_QUOTED: begin
        if (b == CHAR_QUOTE || b == CHAR_NUL) begin
          push_result(8'd0, 1'b1, kept_bytes, 1'b0, 1'b1, 1'b0);
          if (b == CHAR_NUL) push_result(8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1);
          scan_state = MODE_SKIP;
          kept_bytes = 8'd0;
        end else begin
          keep_token_byte(b);
        end
      end
      default: begin
        scan_state = MODE_SKIP;
        kept_bytes = 8'd0;
        if (b == CHAR_NUL) begin
          push_result(8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1);
        end else if (is_text_space(b)) begin
        end else if (b == CHAR_SLASH) begin
          scan_state = MODE_SLASH;
        end else if (b == CHAR_QUOTE) begin
          scan_state = MODE_QUOTED;
        end else begin
          scan_state = MODE_WORD;
          keep_token_byte(b);
        end
      end
    endcase
  endtask

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(string name, int got, int exp_val);
    if (got != exp_val)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp_val));
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: byte %0d end %0b eot %0b",
                                  out_token_byte, out_is_token_end, out_end_of_text));
      end else begin
        want = pending_results.pop_front();
        check_field("token_byte", int'(out_token_byte), int'(want.token_byte));
        check_field("is_token_end", int'(out_is_token_end), int'(want.is_token_end));
        check_field("token_length", int'(out_token_length), int'(want.token_length));
        check_field("discarded", int'(out_discarded), int'(want.discarded));
        check_field("was_quoted", int'(out_was_quoted), int'(want.was_quoted));
        check_field("end_of_text", int'(out_end_of_text), int'(want.end_of_text));
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    out_ready <= !out_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // long receiver hold-off
  always begin
    @(hold_go);
    @(posedge clk);
    out_hold = 1'b1;
    repeat (hold_len) @(posedge clk);
    out_hold = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_text_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_text_byte <= b;
    do @(posedge clk); while (!in_ready);
    tokenize_byte(b);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_high_space(logic v);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    high_space = v;
  endtask

  task automatic set_idle(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  function automatic logic [7:0] pick_word_char();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (is_text_space(b));
    return b;
  endfunction

  function automatic logic [7:0] pick_separator();
    if (high_space && $urandom_range(3) == 0) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(1, 32));
  endfunction

  task automatic send_word(int len);
    repeat (len) send_text_byte(pick_word_char());
  endtask

  task automatic send_quoted(int len, logic [7:0] closer);
    logic [7:0] b;
    send_text_byte(CHAR_QUOTE);
    repeat (len) begin
      do b = 8'($urandom_range(1, 255)); while (b == CHAR_QUOTE);
      send_text_byte(b);
    end
    send_text_byte(closer);
  endtask

  task automatic send_comment(int len);
    logic [7:0] b;
    send_text_byte(CHAR_SLASH);
    send_text_byte(CHAR_SLASH);
    repeat (len) begin
      do b = 8'($urandom_range(1, 255)); while (b == CHAR_NL);
      send_text_byte(b);
    end
    send_text_byte($urandom_range(9) == 0 ? CHAR_NUL : CHAR_NL);
  endtask

  task automatic end_word();
    send_text_byte($urandom_range(9) == 0 ? CHAR_NUL : pick_separator());
  endtask

  task automatic test_directed_tokens();
    logic [7:0] seq [$];
    write_high_space(1'b1);
    seq = '{CHAR_NUL, "w", CHAR_QUOTE, 8'h20, CHAR_QUOTE, "x", " ", "y", CHAR_QUOTE,
            CHAR_SLASH, CHAR_SLASH, "c", CHAR_NL, CHAR_SLASH, "z", 8'h09,
            CHAR_SLASH, CHAR_NUL, "q", 8'hff, CHAR_QUOTE, CHAR_NUL,
            CHAR_SLASH, CHAR_SLASH, CHAR_NUL, 8'h7f, 8'h01};
    foreach (seq[i]) send_text_byte(seq[i]);
  endtask

  task automatic test_high_bytes_as_chars();
    logic [7:0] seq [$];
    write_high_space(1'b0);
    seq = '{8'h80, 8'hff, " ", CHAR_QUOTE, 8'hc3, 8'h20, CHAR_QUOTE, 8'h21, CHAR_NUL};
    foreach (seq[i]) send_text_byte(seq[i]);
  endtask

  task automatic test_long_tokens();
    write_high_space(1'b1);
    send_word(MAX_LEN + 1);
    send_text_byte(CHAR_NUL);
    send_quoted(MAX_LEN + 1, CHAR_QUOTE);
  endtask

  task automatic test_random_text(int n_items);
    int pick;
    begin : gen
      int sent;
      sent = 0;
      while (sent < n_items) begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          pick = $urandom_range(1, 10);
          send_word(pick);
          end_word();
          sent += pick + 1;
        end else if (pick < 50) begin
          pick = $urandom_range(0, 8);
          send_quoted(pick, $urandom_range(9) == 0 ? CHAR_NUL : CHAR_QUOTE);
          sent += pick + 2;
        end else if (pick < 60) begin
          pick = $urandom_range(0, 6);
          send_comment(pick);
          sent += pick + 3;
        end else if (pick < 70) begin
          send_text_byte(CHAR_SLASH);
          pick = $urandom_range(0, 5);
          send_word(pick);
          end_word();
          sent += pick + 2;
        end else if (pick < 78) begin
          send_text_byte(CHAR_NUL);
          sent += 1;
        end else if (pick < 90) begin
          pick = $urandom_range(1, 4);
          repeat (pick) send_text_byte(8'($urandom_range(0, 255)));
          sent += pick;
        end else begin
          pick = $urandom_range(11, 40);
          send_word(pick);
          end_word();
          sent += pick + 1;
        end
      end
    end
  endtask

  task automatic test_backpressure();
    set_idle(0, 0);
    write_high_space(1'b1);
    hold_len = 60;
    -> hold_go;
    repeat (2) begin
      send_word(8);
      send_text_byte(CHAR_NUL);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b0;
    in_valid      = 1'b0;
    in_text_byte  = 8'd0;
    out_hold      = 1'b0;
    hold_len      = 0;
    error_count   = 0;
    cycle_count   = 0;
    scan_state    = MODE_SKIP;
    kept_bytes    = 8'd0;
    high_space    = 1'b1;
    set_idle(12, 71);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_tokens();
    test_high_bytes_as_chars();
    test_long_tokens();

    write_high_space(1'b1);
    test_random_text(15);
    set_idle(71, 12);
    write_high_space(1'b0);
    test_random_text(15);
    set_idle(0, 0);
    write_high_space(1'($urandom_range(1)));
    test_random_text(15);
    test_backpressure();

    wait_idle();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: script_tokenizer_core.f
sv/sctok_pkg.sv
sv/script_tokenizer_core.sv
dv/tb_top.sv
